### rtl/bsgi_pkg.sv
package bsgi_pkg;

  localparam int GRID_COLS_DEF = 256;
  localparam int GRID_ROWS_DEF = 128;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IDX_W      = 15;
  localparam int BAND_W     = 24;
  localparam int CELL_W     = 3 * BAND_W;
  localparam int POS_W      = 65;
  localparam int RECIP_SH   = 28;

  localparam logic [CFG_IDX_W-1:0] REG_LON_ORIGIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_ORIGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COL_SCALE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_SCALE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_USED  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED  = 3'd5;

  localparam logic signed [31:0] COL_SCALE_RST = 32'sd65536;
  localparam logic signed [31:0] ROW_SCALE_RST = -32'sd65536;
  localparam logic [8:0]         COLS_USED_RST = 9'd256;
  localparam logic [7:0]         ROWS_USED_RST = 8'd128;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic [IDX_W-1:0]         cell_index;
    logic signed [BAND_W-1:0] cell_shift_x;
    logic signed [BAND_W-1:0] cell_shift_y;
    logic signed [BAND_W-1:0] cell_shift_z;
    logic signed [31:0]       lon;
    logic signed [31:0]       lat;
  } req_t;

  typedef struct packed {
    logic signed [BAND_W-1:0] vel_x;
    logic signed [BAND_W-1:0] vel_y;
    logic signed [BAND_W-1:0] vel_z;
  } rsp_t;

endpackage

### rtl/bsgi_ram.sv
module bsgi_ram #(
  parameter int W = 72,
  parameter int D = 8192
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                    wdata,
  input  logic                            re,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                    rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/bsgi_locate.sv
module bsgi_locate #(
  parameter int W = 8
) (
  input  logic signed [64:0] pos,
  input  logic [W-1:0]       count_m1,
  output logic [W-1:0]       lo,
  output logic [W-1:0]       hi,
  output logic [15:0]        frac
);

  logic signed [64:0] top;
  logic [64:0]        p;

  assign top = signed'(65'(count_m1) << 44);

  always_comb begin
    if (pos < 0) begin
      p = '0;
    end else if (pos > top) begin
      p = top;
    end else begin
      p = pos;
    end
  end

  assign lo   = p[44 +: W];
  assign frac = p[43:28];
  assign hi   = (lo < count_m1) ? lo + W'(1) : lo;

endmodule

### rtl/bsgi_blend.sv
module bsgi_blend (
  input  logic               clk,
  input  logic               en_a,
  input  logic               en_b,
  input  logic signed [23:0] p00,
  input  logic signed [23:0] p01,
  input  logic signed [23:0] p10,
  input  logic signed [23:0] p11,
  input  logic [15:0]        fx,
  input  logic [15:0]        fy,
  output logic signed [23:0] res
);

  logic signed [16:0] fxs;
  logic signed [16:0] fys;
  logic signed [24:0] du;
  logic signed [24:0] dl;
  logic signed [40:0] mu;
  logic signed [40:0] ml;
  logic signed [40:0] upper;
  logic signed [40:0] lower;
  logic [15:0]        fy_a;
  logic signed [41:0] d2;
  logic signed [58:0] m2;
  logic signed [58:0] sum;
  logic signed [58:0] biased;
  logic signed [26:0] q;

  assign fxs = $signed({1'b0, fx});
  assign fys = $signed({1'b0, fy_a});
  assign du  = p01 - p00;
  assign dl  = p11 - p10;
  assign mu  = du * fxs;
  assign ml  = dl * fxs;

  always_ff @(posedge clk) begin
    if (en_a) begin
      upper <= (41'(p00) <<< 16) + mu;
      lower <= (41'(p10) <<< 16) + ml;
      fy_a  <= fy;
    end
  end

  assign d2 = lower - upper;
  assign m2 = d2 * fys;

  always_ff @(posedge clk) begin
    if (en_b) begin
      sum <= (59'(upper) <<< 16) + m2;
    end
  end

  assign biased = sum + (59'sd1 <<< 31);
  assign q      = biased[58:32];

  always_comb begin
    if (q > 27'sd8388607) begin
      res = 24'sh7fffff;
    end else if (q < -27'sd8388608) begin
      res = 24'sh800000;
    end else begin
      res = q[23:0];
    end
  end

endmodule

### rtl/bilinear_shift_grid_interpolator.sv
// channel  | signals                      | carries
// req      | req_valid, req_ready, req    | cell write or point query item
// rsp      | rsp_valid, rsp_ready, rsp    | interpolated x, y, z shifts
// cfg      | cfg_we, cfg_index, cfg_data  | register write, no wait
// one item per cycle sustained while rsp is not stalled; a query result is registered through every stage before rsp
// the four corner cells come from four row/column parity banks, one read port each
// a write item with an in-range index is written to its bank from the registered row/column split and makes no result
// rst clears the stage valid bits and sets config registers to their defaults; grid contents are not cleared
// a stalled rsp holds the pipeline back stage by stage, bubbles are squeezed out
module bilinear_shift_grid_interpolator
  import bsgi_pkg::*;
#(
  parameter int GRID_COLS = GRID_COLS_DEF,
  parameter int GRID_ROWS = GRID_ROWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_t                  rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW    = $clog2(GRID_COLS);
  localparam int RW    = $clog2(GRID_ROWS);
  localparam int HC    = (GRID_COLS + 1) / 2;
  localparam int HR    = (GRID_ROWS + 1) / 2;
  localparam int BD    = HC * HR;
  localparam int BAW   = (BD > 1) ? $clog2(BD) : 1;
  localparam int CELLS = GRID_COLS * GRID_ROWS;
  localparam int RECIP = (1 << RECIP_SH) / GRID_COLS;

  logic signed [31:0] lon_origin;
  logic signed [31:0] lat_origin;
  logic signed [31:0] col_scale;
  logic signed [31:0] row_scale;
  logic [8:0]         columns_in_use;
  logic [7:0]         rows_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      lon_origin     <= '0;
      lat_origin     <= '0;
      col_scale      <= COL_SCALE_RST;
      row_scale      <= ROW_SCALE_RST;
      columns_in_use <= COLS_USED_RST;
      rows_in_use    <= ROWS_USED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LON_ORIGIN: lon_origin     <= cfg_data;
        REG_LAT_ORIGIN: lat_origin     <= cfg_data;
        REG_COL_SCALE:  col_scale      <= cfg_data;
        REG_ROW_SCALE:  row_scale      <= cfg_data;
        REG_COLS_USED:  columns_in_use <= cfg_data[8:0];
        REG_ROWS_USED:  rows_in_use    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] col_m1;
  logic [RW-1:0] row_m1;

  always_comb begin
    if (columns_in_use == 9'd0) begin
      col_m1 = '0;
    end else if (32'(columns_in_use) > GRID_COLS) begin
      col_m1 = CW'(GRID_COLS - 1);
    end else begin
      col_m1 = CW'(columns_in_use - 9'd1);
    end
    if (rows_in_use == 8'd0) begin
      row_m1 = '0;
    end else if (32'(rows_in_use) > GRID_ROWS) begin
      row_m1 = RW'(GRID_ROWS - 1);
    end else begin
      row_m1 = RW'(rows_in_use - 8'd1);
    end
  end

  logic v1, v2, v3, v4, v5, v6, v7;
  logic en1, en2, en3, en4, en5, en6, en7;
  logic cmd3;

  assign en7       = !v7 || rsp_ready;
  assign en6       = !v6 || en7;
  assign en5       = !v5 || en6;
  assign en4       = !v4 || en5;
  assign en3       = !v3 || en4;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign req_ready = en1;
  assign rsp_valid = v7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (en1) v1 <= req_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3 && (cmd3 == CMD_QUERY);
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
      if (en7) v7 <= v6;
    end
  end

  // stage 1: offsets and write index reciprocal product
  logic               cmd1;
  logic [IDX_W-1:0]   idx1;
  logic [CELL_W-1:0]  data1;
  logic signed [32:0] dlon1;
  logic signed [32:0] dlat1;
  logic [42:0]        q1;

  always_ff @(posedge clk) begin
    if (en1) begin
      cmd1  <= req.cmd;
      idx1  <= req.cell_index;
      data1 <= {req.cell_shift_x, req.cell_shift_y, req.cell_shift_z};
      dlon1 <= 33'(req.lon) - 33'(lon_origin);
      dlat1 <= 33'(req.lat) - 33'(lat_origin);
      q1    <= 43'(req.cell_index) * 43'(RECIP);
    end
  end

  // stage 2: grid positions and row estimate times width
  logic               cmd2;
  logic [IDX_W-1:0]   idx2;
  logic [CELL_W-1:0]  data2;
  logic signed [64:0] posx2;
  logic signed [64:0] posy2;
  logic [IDX_W-1:0]   est2;
  logic [IDX_W-1:0]   rc2;
  logic [IDX_W-1:0]   est1;

  assign est1 = q1[RECIP_SH +: IDX_W];

  always_ff @(posedge clk) begin
    if (en2) begin
      cmd2  <= cmd1;
      idx2  <= idx1;
      data2 <= data1;
      posx2 <= 65'(dlon1) * 65'(col_scale);
      posy2 <= 65'(dlat1) * 65'(row_scale);
      est2  <= est1;
      rc2   <= IDX_W'(32'(est1) * GRID_COLS);
    end
  end

  // stage 3: clamp and locate corners, finish write row/column split
  logic [CW-1:0]    c0_n, c1_n;
  logic [RW-1:0]    r0_n, r1_n;
  logic [15:0]      fx_n, fy_n;
  logic [IDX_W-1:0] rem2;
  logic [IDX_W-1:0] wrow_n;
  logic [IDX_W-1:0] wcol_n;

  bsgi_locate #(.W(CW)) u_loc_col (
    .pos(posx2), .count_m1(col_m1), .lo(c0_n), .hi(c1_n), .frac(fx_n)
  );

  bsgi_locate #(.W(RW)) u_loc_row (
    .pos(posy2), .count_m1(row_m1), .lo(r0_n), .hi(r1_n), .frac(fy_n)
  );

  assign rem2 = idx2 - rc2;

  always_comb begin
    if (32'(rem2) >= GRID_COLS) begin
      wrow_n = est2 + IDX_W'(1);
      wcol_n = IDX_W'(32'(rem2) - GRID_COLS);
    end else begin
      wrow_n = est2;
      wcol_n = rem2;
    end
  end

  logic [CELL_W-1:0] data3;
  logic [CW-1:0]     c0_3, c1_3, wcol3;
  logic [RW-1:0]     r0_3, r1_3, wrow3;
  logic [15:0]       fx3, fy3;
  logic              wok3;

  always_ff @(posedge clk) begin
    if (en3) begin
      cmd3  <= cmd2;
      data3 <= data2;
      c0_3  <= c0_n;
      c1_3  <= c1_n;
      r0_3  <= r0_n;
      r1_3  <= r1_n;
      fx3   <= fx_n;
      fy3   <= fy_n;
      wrow3 <= RW'(wrow_n);
      wcol3 <= CW'(wcol_n);
      wok3  <= 32'(idx2) < CELLS;
    end
  end

  // stage 4: banked grid, read data registered in the ram
  function automatic logic [BAW-1:0] baddr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    baddr = BAW'(int'(r >> 1) * HC + int'(c >> 1));
  endfunction

  logic           wr_go;
  logic [BAW-1:0] wa;
  logic [CELL_W-1:0] rd [4];

  assign wr_go = v3 && (cmd3 == CMD_WRITE) && wok3 && en4;
  assign wa    = baddr(wrow3, wcol3);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic RP = 1'(b / 2);
    localparam logic CP = 1'(b % 2);
    logic [RW-1:0]  rr;
    logic [CW-1:0]  cc;
    logic           wsel;

    assign rr   = (r0_3[0] == RP) ? r0_3 : r1_3;
    assign cc   = (c0_3[0] == CP) ? c0_3 : c1_3;
    assign wsel = (wrow3[0] == RP) && (wcol3[0] == CP);

    bsgi_ram #(.W(CELL_W), .D(BD)) u_ram (
      .clk(clk),
      .we(wr_go && wsel),
      .waddr(wa),
      .wdata(data3),
      .re(en4),
      .raddr(baddr(rr, cc)),
      .rdata(rd[b])
    );
  end

  logic        r0p4, r1p4, c0p4, c1p4;
  logic [15:0] fx4, fy4;

  always_ff @(posedge clk) begin
    if (en4) begin
      r0p4 <= r0_3[0];
      r1p4 <= r1_3[0];
      c0p4 <= c0_3[0];
      c1p4 <= c1_3[0];
      fx4  <= fx3;
      fy4  <= fy3;
    end
  end

  // stages 5 and 6: blend per band
  logic [CELL_W-1:0]        k00, k01, k10, k11;
  logic signed [BAND_W-1:0] res [3];

  assign k00 = rd[{r0p4, c0p4}];
  assign k01 = rd[{r0p4, c1p4}];
  assign k10 = rd[{r1p4, c0p4}];
  assign k11 = rd[{r1p4, c1p4}];

  for (genvar k = 0; k < 3; k++) begin : g_band
    localparam int HI = CELL_W - 1 - BAND_W * k;
    bsgi_blend u_blend (
      .clk(clk),
      .en_a(en5),
      .en_b(en6),
      .p00(k00[HI -: BAND_W]),
      .p01(k01[HI -: BAND_W]),
      .p10(k10[HI -: BAND_W]),
      .p11(k11[HI -: BAND_W]),
      .fx(fx4),
      .fy(fy4),
      .res(res[k])
    );
  end

  // stage 7: output register
  always_ff @(posedge clk) begin
    if (en7) begin
      rsp.vel_x <= res[0];
      rsp.vel_y <= res[1];
      rsp.vel_z <= res[2];
    end
  end

endmodule

### rtl/bsgi_checker.sv
module bsgi_checker
  import bsgi_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  a_rst_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_rst_ready: assert property (@(posedge clk) rst |=> req_ready)
    else $error("not ready right after reset");

  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("input stalled while output is empty");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled result item changed");

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("waiting input item changed");

endmodule

bind bilinear_shift_grid_interpolator bsgi_checker u_chk (.*);
